### rtl/core/column_ascending_sort_top_assert.svh
`ifndef COLUMN_ASCENDING_SORT_TOP_ASSERT_SVH
`define COLUMN_ASCENDING_SORT_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("column sort check failed");

// next-cycle implication, sampled on clk, off during reset
`define CAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("column sort check failed");

`endif

### rtl/core/cas_pkg.sv
package cas_pkg;

  localparam int MAX_ROWS = 64;
  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int SET_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] data;
  } cas_link_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } cas_state_t;

endpackage

### rtl/core/cas_cell.sv
module cas_cell
  import cas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift,
  input  cas_link_t ins,
  input  cas_link_t right,
  output cas_link_t held,
  output cas_link_t pass
);

  logic                       held_vld_r, held_vld_nxt;
  logic signed [SAMPLE_W-1:0] held_r, held_nxt;
  logic                       pass_vld_r, pass_vld_nxt;
  logic signed [SAMPLE_W-1:0] pass_r, pass_nxt;

  always_comb begin
    held_vld_nxt = held_vld_r;
    held_nxt     = held_r;
    pass_vld_nxt = 1'b0;
    pass_nxt     = pass_r;
    if (shift) begin
      held_vld_nxt = right.vld;
      held_nxt     = right.data;
    end else if (ins.vld) begin
      if (!held_vld_r) begin
        held_vld_nxt = 1'b1;
        held_nxt     = ins.data;
      end else if (ins.data < held_r) begin
        held_nxt     = ins.data;
        pass_vld_nxt = 1'b1;
        pass_nxt     = held_r;
      end else begin
        pass_vld_nxt = 1'b1;
        pass_nxt     = ins.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else begin
      held_vld_r <= held_vld_nxt;
      pass_vld_r <= pass_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    pass_r <= pass_nxt;
  end

  assign held.vld  = held_vld_r;
  assign held.data = held_r;
  assign pass.vld  = pass_vld_r;
  assign pass.data = pass_r;

endmodule

### rtl/core/cas_chain.sv
module cas_chain
  import cas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift,
  input  cas_link_t inj,
  output cas_link_t head,
  output logic      tail_spill
);

  cas_link_t held_w [MAX_ROWS];
  cas_link_t pass_w [MAX_ROWS];
  cas_link_t ins_w  [MAX_ROWS];
  cas_link_t right_w[MAX_ROWS];

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign ins_w[i] = inj;
    end else begin : g_mid
      assign ins_w[i] = pass_w[i-1];
    end
    if (i == MAX_ROWS - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_inner
      assign right_w[i] = held_w[i+1];
    end
    cas_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .ins   (ins_w[i]),
      .right (right_w[i]),
      .held  (held_w[i]),
      .pass  (pass_w[i])
    );
  end

  assign head       = held_w[0];
  // the fill count keeps the row from overflowing, so this never rises
  assign tail_spill = pass_w[MAX_ROWS-1].vld;

endmodule

### rtl/core/column_ascending_sort_top.sv
// column_ascending_sort_top: ascending sort of one column batch.
// Input channel (in_valid / in_stall): one signed Q16.16 sample per request,
// in_final_item high on the last sample of the column. Loading takes one
// request per cycle through a row of 64 insertion cells, each keeping the
// smaller value and handing the larger one to its right neighbor.
// Samples past 64 in a batch are dropped and the batch is flagged truncated.
// After the final request, in_stall stays high while the row settles and
// then while the sorted column drains out of the head cell, one result per
// cycle while out_stall is low, smallest first.
// Output channel (out_valid / out_stall): out_sorted_sample, out_final_result
// on the largest element, out_truncated on every result of a clipped batch.
// The first result of a batch appears once the row has settled, and the
// rest follow one per cycle while out_stall is low.
// The output register holds its result while out_stall is high, and the
// drain pauses; loading of the next batch starts as soon as the last result
// has entered the output register.
// Reset (rst_n low, synchronous) empties the row and clears the counts.
module column_ascending_sort_top
  import cas_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_final_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sorted_sample,
  output logic                       out_final_result,
  output logic                       out_truncated
);

  cas_state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [SET_W-1:0]           settle_r, settle_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_final_r;
  logic                       out_trunc_r;

  logic      in_acc;
  logic      full;
  logic      out_load;
  cas_link_t inj;
  cas_link_t head;
  logic      tail_spill;

  assign full     = (fill_r == CNT_W'(MAX_ROWS));
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DRAIN) && (!out_valid_r || !out_stall);

  assign inj.vld  = in_acc && !full;
  assign inj.data = in_sample;

  cas_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift      (out_load),
    .inj        (inj),
    .head       (head),
    .tail_spill (tail_spill)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    settle_nxt    = settle_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (in_final_item) begin
            state_nxt  = ST_SETTLE;
            settle_nxt = '0;
          end
        end
      end
      ST_SETTLE: begin
        settle_nxt = settle_r + SET_W'(1);
        if (settle_r == SET_W'(MAX_ROWS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          fill_nxt      = fill_r - CNT_W'(1);
          if (fill_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      settle_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt || tail_spill;
      settle_r    <= settle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= head.data;
      out_final_r  <= (fill_r == CNT_W'(1));
      out_trunc_r  <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sorted_sample = out_sample_r;
  assign out_final_result  = out_final_r;
  assign out_truncated     = out_trunc_r;

endmodule

### rtl/core/cas_checker.sv
`include "column_ascending_sort_top_assert.svh"

module cas_checker
  import cas_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [SAMPLE_W-1:0] in_sample,
  input logic                       in_final_item,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] out_sorted_sample,
  input logic                       out_final_result,
  input logic                       out_truncated
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // a stalled result request holds
  `CAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_sorted_sample) && $stable(out_final_result))

  // the final sample of a column closes the input side
  `CAS_ASSERT_NEXT(a_final_stalls, in_acc && in_final_item, in_stall)

  // within one column the results never decrease
  `CAS_ASSERT_NEXT(a_ascending, out_acc && !out_final_result,
    !out_valid || (out_sorted_sample >= $past(out_sorted_sample)))

  // the truncated flag is the same on every result of a column
  `CAS_ASSERT_NEXT(a_trunc_const, out_acc && !out_final_result,
    !out_valid || (out_truncated == $past(out_truncated)))

  // no sample enters while results of the previous column still drain
  `CAS_ASSERT_NOW(a_no_overlap, out_valid && !out_final_result, in_stall)

endmodule

bind column_ascending_sort_top cas_checker u_cas_checker (.*);
